### design/rate_limited_multi_watchdog_defines.svh
// Assertion macros shared by the watchdog bank checker.
`ifndef RATE_LIMITED_MULTI_WATCHDOG_DEFINES_SVH
`define RATE_LIMITED_MULTI_WATCHDOG_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rlmw_pkg.sv
// Types, codes and constants of the rate-limited watchdog bank.
package rlmw_pkg;

    localparam int DEFAULT_CHANNELS = 8;
    localparam logic [15:0] RATELIMIT_RESET = 16'd300;
    localparam logic [2:0] BURST_LIMIT = 3'd3;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_TOUCH   = 2'd1,
        REQ_DISABLE = 2'd2,
        REQ_DELETE  = 2'd3
    } req_t;

    localparam logic [1:0] MODE_DISABLED = 2'd0;
    localparam logic [1:0] MODE_ENABLED  = 2'd1;
    localparam logic [1:0] MODE_EXPIRED  = 2'd2;

    localparam logic [2:0] KIND_DUMP       = 3'd0;
    localparam logic [2:0] KIND_SUPPRESSED = 3'd1;
    localparam logic [2:0] KIND_TOUCHED    = 3'd2;
    localparam logic [2:0] KIND_DISABLED   = 3'd3;
    localparam logic [2:0] KIND_DELETED    = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] remaining;
        logic [31:0] touched;
    } chan_entry_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  chan;
        logic [31:0] inactive;
        logic        last;
    } report_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic rd_cmd;
        logic scan_write;
        logic cmd_write;
        logic flush;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_tick;
        logic in_ch_ok;
        logic expire_now;
        logic cmd_expired;
        logic pend_valid;
        logic out_free;
        logic idx_last;
    } ctrl_stat_t;

endpackage

### design/rlmw_ctrl.sv
// Sequencing state machine of the watchdog bank.
module rlmw_ctrl
    import rlmw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  ctrl_stat_t stat,
    output logic       in_stall,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SCAN_RD = 6'b000010,
        ST_SCAN_EV = 6'b000100,
        ST_FLUSH   = 6'b001000,
        ST_CMD_RD  = 6'b010000,
        ST_CMD_EV  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (stat.in_tick)
                    begin
                        state_next = ST_SCAN_RD;
                    end
                    else if (stat.in_ch_ok)
                    begin
                        state_next = ST_CMD_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_EV;
            end
            ST_SCAN_EV:
            begin
                // An expiry needs the pending slot; hold while it cannot drain.
                if (!(stat.expire_now && stat.pend_valid && !stat.out_free))
                begin
                    cmd.scan_write = 1'b1;
                    state_next = stat.idx_last ? ST_FLUSH : ST_SCAN_RD;
                end
            end
            ST_FLUSH:
            begin
                if (!stat.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.flush = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CMD_RD:
            begin
                cmd.rd_cmd = 1'b1;
                state_next = ST_CMD_EV;
            end
            ST_CMD_EV:
            begin
                // Keep the read on the addressed channel while the report waits.
                cmd.rd_cmd = 1'b1;
                if (!(stat.cmd_expired && !stat.out_free))
                begin
                    cmd.cmd_write = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/rlmw_dpath.sv
// Channel memory, clock, rate limiter and report registers of the watchdog bank.
module rlmw_dpath
    import rlmw_pkg::*;
#(
    parameter int CHANNELS = DEFAULT_CHANNELS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_cmd_t   cmd,
    output ctrl_stat_t  stat,
    input  logic [1:0]  req_type,
    input  logic [2:0]  channel,
    input  logic [15:0] timeout_seconds,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [2:0]  report_kind,
    output logic [2:0]  report_channel,
    output logic [31:0] inactive_seconds,
    output logic        last
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [6:0] CHAN_COUNT = 7'(CHANNELS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

    // Control state.
    logic [31:0]         now_reg, now_next;
    logic [31:0]         last_alarm_reg, last_alarm_next;
    logic [2:0]          alarm_count_reg, alarm_count_next;
    logic [15:0]         ratelimit_reg;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CHANNELS-1:0] valid_reg;
    logic                rd_valid_reg;
    logic                pend_valid_reg, pend_valid_next;
    logic                out_valid_reg, out_valid_next;

    // Payload.
    req_t                req_reg;
    logic [2:0]          ch_reg;
    logic [15:0]         tmo_reg;
    chan_entry_t         rd_entry_reg;
    report_t             pend_reg, pend_next;
    report_t             out_rep_reg, out_rep_next;

    chan_entry_t         mem [CHANNELS];

    chan_entry_t         entry;
    chan_entry_t         wr_entry;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    ch_addr;
    logic [6:0]          ch_ext;
    logic [6:0]          idx_ext;
    logic                enabled;
    logic                expired;
    logic                expire_now;
    logic [31:0]         inactive;
    logic [31:0]         delta;
    logic                in_win;
    logic                suppress;
    logic                out_free;
    logic [2:0]          cmd_kind;
    report_t             scan_rep;

    assign ch_ext  = {4'd0, ch_reg};
    assign ch_addr = ch_ext[IDX_W-1:0];
    assign idx_ext = 7'(idx_reg);
    assign rd_addr = cmd.rd_cmd ? ch_addr : idx_reg;

    // An entry never written since reset reads as a disabled, zeroed channel.
    assign entry      = rd_valid_reg ? rd_entry_reg : '0;
    assign enabled    = (entry.mode == MODE_ENABLED);
    assign expired    = (entry.mode == MODE_EXPIRED);
    assign expire_now = enabled && (entry.remaining <= 16'd1);
    assign inactive   = now_reg - entry.touched;
    assign delta      = now_reg - last_alarm_reg;
    assign in_win     = (delta < {16'd0, ratelimit_reg});
    assign suppress   = in_win && (alarm_count_reg > BURST_LIMIT);
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (req_reg)
            REQ_TOUCH:   cmd_kind = KIND_TOUCHED;
            REQ_DISABLE: cmd_kind = KIND_DISABLED;
            default:     cmd_kind = KIND_DELETED;
        endcase
    end

    always_comb
    begin
        scan_rep.kind     = suppress ? KIND_SUPPRESSED : KIND_DUMP;
        scan_rep.chan     = idx_ext[2:0];
        scan_rep.inactive = inactive;
        scan_rep.last     = 1'b0;
    end

    // Channel memory write.
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = idx_reg;
        wr_entry = entry;
        if (cmd.scan_write && enabled)
        begin
            wr_en = 1'b1;
            if (expire_now)
            begin
                wr_entry.mode      = MODE_EXPIRED;
                wr_entry.remaining = 16'd0;
            end
            else
            begin
                wr_entry.remaining = entry.remaining - 16'd1;
            end
        end
        else if (cmd.cmd_write)
        begin
            wr_en            = 1'b1;
            wr_addr          = ch_addr;
            wr_entry.touched = now_reg;
            if (req_reg == REQ_TOUCH)
            begin
                wr_entry.mode      = MODE_ENABLED;
                wr_entry.remaining = tmo_reg;
            end
            else
            begin
                wr_entry.mode = MODE_DISABLED;
                if (req_reg == REQ_DELETE)
                begin
                    wr_entry.remaining = 16'd0;
                end
            end
        end
    end

    always_comb
    begin
        now_next         = now_reg;
        last_alarm_next  = last_alarm_reg;
        alarm_count_next = alarm_count_reg;
        idx_next         = idx_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_rep_next     = out_rep_reg;

        if (cmd.take)
        begin
            idx_next = '0;
            if (stat.in_tick)
            begin
                now_next = now_reg + 32'd1;
            end
        end

        if (cmd.scan_write)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (expire_now)
            begin
                if (!suppress)
                begin
                    if (in_win)
                    begin
                        alarm_count_next = alarm_count_reg + 3'd1;
                    end
                    else
                    begin
                        last_alarm_next  = now_reg;
                        alarm_count_next = 3'd0;
                    end
                end
                // A newer expiry proves the held one was not the final report.
                if (pend_valid_reg)
                begin
                    out_rep_next   = pend_reg;
                    out_valid_next = 1'b1;
                end
                pend_next       = scan_rep;
                pend_valid_next = 1'b1;
            end
        end

        if (cmd.flush)
        begin
            out_rep_next      = pend_reg;
            out_rep_next.last = 1'b1;
            out_valid_next    = 1'b1;
            pend_valid_next   = 1'b0;
        end

        if (cmd.cmd_write && expired)
        begin
            out_rep_next.kind     = cmd_kind;
            out_rep_next.chan     = ch_reg;
            out_rep_next.inactive = inactive;
            out_rep_next.last     = 1'b1;
            out_valid_next        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg         <= '0;
            last_alarm_reg  <= '0;
            alarm_count_reg <= '0;
            ratelimit_reg   <= RATELIMIT_RESET;
            idx_reg         <= '0;
            valid_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            now_reg         <= now_next;
            last_alarm_reg  <= last_alarm_next;
            alarm_count_reg <= alarm_count_next;
            idx_reg         <= idx_next;
            rd_valid_reg    <= valid_reg[rd_addr];
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr_en)
            begin
                ratelimit_reg <= cfg_wr_data;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            req_reg <= req_t'(req_type);
            ch_reg  <= channel;
            tmo_reg <= timeout_seconds;
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_addr];
        pend_reg     <= pend_next;
        out_rep_reg  <= out_rep_next;
    end

    always_comb
    begin
        stat.in_tick     = (req_t'(req_type) == REQ_TICK);
        stat.in_ch_ok    = ({4'd0, channel} < CHAN_COUNT);
        stat.expire_now  = expire_now;
        stat.cmd_expired = expired;
        stat.pend_valid  = pend_valid_reg;
        stat.out_free    = out_free;
        stat.idx_last    = (idx_reg == IDX_LAST);
    end

    assign out_valid        = out_valid_reg;
    assign report_kind      = out_rep_reg.kind;
    assign report_channel   = out_rep_reg.chan;
    assign inactive_seconds = out_rep_reg.inactive;
    assign last             = out_rep_reg.last;

endmodule

### design/rate_limited_multi_watchdog.sv
// Top level of the rate-limited watchdog bank.
//
//   channel   handshake            payload
//   input     in_valid / in_stall  req_type, channel, timeout_seconds
//   result    out_valid/out_stall  report_kind, report_channel, inactive_seconds, last
//   config    cfg_wr_en            cfg_wr_data (rate-limit window, seconds)
//
// A tick request scans every channel before the next accept: each channel gets a read
// state and a write-back state on the one-read, one-write channel memory, then a flush.
// Touch, disable and delete use a read and an evaluate state; a bad channel stays idle.
// Reset clears per-entry valid bits, so the memory needs no clearing pass.
// A stalled result holds the scan when an expiry finds the held report still waiting,
// and holds the final flush or a command report until the output register frees up.
module rate_limited_multi_watchdog
    import rlmw_pkg::*;
#(
    parameter int CHANNELS = DEFAULT_CHANNELS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [2:0]  channel,
    input  logic [15:0] timeout_seconds,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  report_kind,
    output logic [2:0]  report_channel,
    output logic [31:0] inactive_seconds,
    output logic        last,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    rlmw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    rlmw_dpath #(
        .CHANNELS (CHANNELS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .req_type         (req_type),
        .channel          (channel),
        .timeout_seconds  (timeout_seconds),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .report_kind      (report_kind),
        .report_channel   (report_channel),
        .inactive_seconds (inactive_seconds),
        .last             (last)
    );

endmodule

### design/rlmw_checker.sv
// Port-level assertion checker of the watchdog bank and its bind.
`include "rate_limited_multi_watchdog_defines.svh"

module rlmw_checker
    import rlmw_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  req_type,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  report_kind,
    input logic [2:0]  report_channel,
    input logic [31:0] inactive_seconds,
    input logic        last
);

    `CHK_NEXT(a_out_valid_holds, out_valid && out_stall, out_valid, "result valid dropped while stalled")

    `CHK_NEXT(a_out_payload_holds, out_valid && out_stall, $stable(report_kind) && $stable(report_channel) && $stable(inactive_seconds) && $stable(last), "stalled result changed")

    // Reports from touch, disable or delete are always the only report of their request.
    `CHK_SAME(a_cmd_report_last, out_valid && (report_kind == KIND_TOUCHED || report_kind == KIND_DISABLED || report_kind == KIND_DELETED), last, "command report without last")

    // A tick always starts a channel scan, so the next request must wait.
    `CHK_NEXT(a_tick_busy, in_valid && !in_stall && req_type == REQ_TICK, in_stall, "request accepted during a scan")

endmodule

bind rate_limited_multi_watchdog rlmw_checker u_rlmw_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .req_type         (req_type),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .report_kind      (report_kind),
    .report_channel   (report_channel),
    .inactive_seconds (inactive_seconds),
    .last             (last)
);

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the rate-limited watchdog bank with its own prediction of reports.
module tb;
    import rlmw_pkg::*;

    localparam int NCHAN = DEFAULT_CHANNELS;
    localparam int SCAN_CYCLES = 2 * NCHAN + 2;
    localparam int SETTLE_CYCLES = 3 * SCAN_CYCLES;
    localparam int STUCK_LIMIT = 4000;
    localparam int RANDOM_PER_PHASE = 58;
    localparam int RANDOM_PHASES = 5;

    typedef struct packed {
        req_t        op;
        logic [2:0]  chan;
        logic [15:0] tmo;
    } wd_request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = REQ_TICK;
    logic [2:0]  channel = 3'd0;
    logic [15:0] timeout_seconds = 16'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  report_kind;
    logic [2:0]  report_channel;
    logic [31:0] inactive_seconds;
    logic        last;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;

    // Predicted state of the watchdog bank.
    logic [31:0] now_sec;
    logic [31:0] last_alarm;
    logic [2:0]  alarm_burst;
    logic [1:0]  chan_mode [NCHAN];
    logic [15:0] chan_left [NCHAN];
    logic [31:0] chan_touched [NCHAN];
    logic [15:0] rate_window;

    wd_request_t request_queue [$];
    report_t     due_reports [$];
    wd_request_t drive_req;
    wd_request_t taken_req;
    report_t     want_rep;

    int send_idle_pct = 34;
    int recv_idle_pct = 74;
    int errors = 0;
    int stuck_cycles = 0;
    int requests_taken = 0;
    int ticks_taken = 0;
    int reports_seen = 0;
    int dumps_seen = 0;
    int suppressed_seen = 0;

    rate_limited_multi_watchdog u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .channel          (channel),
        .timeout_seconds  (timeout_seconds),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .report_kind      (report_kind),
        .report_channel   (report_channel),
        .inactive_seconds (inactive_seconds),
        .last             (last),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Shared alarm limiter: returns dump or suppressed and updates the window state.
    function automatic logic [2:0] alarm_kind();
        logic in_window;
        in_window = (now_sec - last_alarm) < {16'd0, rate_window};
        if (in_window && alarm_burst > BURST_LIMIT)
            return KIND_SUPPRESSED;
        if (in_window)
            alarm_burst = alarm_burst + 3'd1;
        else
        begin
            last_alarm = now_sec;
            alarm_burst = 3'd0;
        end
        return KIND_DUMP;
    endfunction

    task automatic watchdog_step(input wd_request_t r);
        report_t hits [NCHAN];
        int n;
        n = 0;
        if (r.op == REQ_TICK)
        begin
            ticks_taken++;
            now_sec = now_sec + 32'd1;
            for (int i = 0; i < NCHAN; i++)
            begin
                if (chan_mode[i] == MODE_ENABLED)
                begin
                    if (chan_left[i] > 16'd1)
                        chan_left[i] = chan_left[i] - 16'd1;
                    else
                    begin
                        chan_left[i] = 16'd0;
                        chan_mode[i] = MODE_EXPIRED;
                        hits[n].kind = alarm_kind();
                        hits[n].chan = 3'(i);
                        hits[n].inactive = now_sec - chan_touched[i];
                        hits[n].last = 1'b0;
                        n++;
                    end
                end
            end
            if (n > 0)
                hits[n - 1].last = 1'b1;
            for (int k = 0; k < n; k++)
                due_reports.push_back(hits[k]);
        end
        else
        begin
            // Only an expired channel reports; the state changes either way.
            if (chan_mode[r.chan] == MODE_EXPIRED)
            begin
                hits[0].kind = (r.op == REQ_TOUCH) ? KIND_TOUCHED :
                               (r.op == REQ_DISABLE) ? KIND_DISABLED : KIND_DELETED;
                hits[0].chan = r.chan;
                hits[0].inactive = now_sec - chan_touched[r.chan];
                hits[0].last = 1'b1;
                due_reports.push_back(hits[0]);
            end
            chan_touched[r.chan] = now_sec;
            if (r.op == REQ_TOUCH)
            begin
                chan_mode[r.chan] = MODE_ENABLED;
                chan_left[r.chan] = r.tmo;
            end
            else
            begin
                chan_mode[r.chan] = MODE_DISABLED;
                if (r.op == REQ_DELETE)
                    chan_left[r.chan] = 16'd0;
            end
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    function automatic wd_request_t random_request();
        wd_request_t r;
        int pick;
        pick = $urandom_range(0, 99);
        r.chan = 3'($urandom_range(0, NCHAN - 1));
        r.tmo = 16'($urandom);
        if (pick < 45)
            r.op = REQ_TICK;
        else if (pick < 75)
        begin
            r.op = REQ_TOUCH;
            // Short timeouts keep channels expiring; some stay fully random.
            case ($urandom_range(0, 9))
                0, 1: r.tmo = 16'($urandom);
                2, 3: r.tmo = 16'($urandom_range(0, 40));
                default: r.tmo = 16'($urandom_range(0, 5));
            endcase
        end
        else if (pick < 87)
            r.op = REQ_DISABLE;
        else
            r.op = REQ_DELETE;
        return r;
    endfunction

    task automatic push_req(input req_t op, input logic [2:0] ch, input logic [15:0] tmo);
        wd_request_t r;
        r.op = op;
        r.chan = ch;
        r.tmo = tmo;
        request_queue.push_back(r);
    endtask

    task automatic drain_and_settle();
        while (request_queue.size() > 0 || in_valid || due_reports.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [15:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        rate_window = value;
    endtask

    // Request driver.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (request_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                drive_req = request_queue.pop_front();
                in_valid <= 1'b1;
                req_type <= drive_req.op;
                channel <= drive_req.chan;
                timeout_seconds <= drive_req.tmo;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Report receiver back-pressure.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Monitor: predicts on each accepted request, checks each accepted report.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                taken_req.op = req_t'(req_type);
                taken_req.chan = channel;
                taken_req.tmo = timeout_seconds;
                watchdog_step(taken_req);
                requests_taken++;
            end
            if (out_valid && !out_stall)
            begin
                reports_seen++;
                if (report_kind == KIND_DUMP)
                    dumps_seen++;
                if (report_kind == KIND_SUPPRESSED)
                    suppressed_seen++;
                if (due_reports.size() == 0)
                begin
                    $display("%0t: unexpected report, expected none, actual kind %0d ch %0d inactive %0d last %0d",
                             $time, report_kind, report_channel, inactive_seconds, last);
                    errors++;
                end
                else
                begin
                    want_rep = due_reports.pop_front();
                    check_field("report_kind", 32'(want_rep.kind), 32'(report_kind));
                    check_field("report_channel", 32'(want_rep.chan), 32'(report_channel));
                    check_field("inactive_seconds", want_rep.inactive, inactive_seconds);
                    check_field("last", 32'(want_rep.last), 32'(last));
                end
            end
        end
    end

    // Hang detection: too long without any request or report moving.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        logic [15:0] next_window;
        now_sec = 32'd0;
        last_alarm = 32'd0;
        alarm_burst = 3'd0;
        rate_window = RATELIMIT_RESET;
        for (int i = 0; i < NCHAN; i++)
        begin
            chan_mode[i] = MODE_DISABLED;
            chan_left[i] = 16'd0;
            chan_touched[i] = 32'd0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset window: one tick expires seven channels at once,
        // so the limiter dumps four and suppresses the rest.
        push_req(REQ_TOUCH, 3'd0, 16'd0);
        for (int i = 1; i <= 5; i++)
            push_req(REQ_TOUCH, 3'(i), 16'd1);
        push_req(REQ_TOUCH, 3'd6, 16'd0);
        push_req(REQ_TOUCH, 3'd7, 16'hFFFF);
        push_req(REQ_TICK, 3'd0, 16'd0);
        push_req(REQ_TOUCH, 3'd0, 16'd2);
        push_req(REQ_DISABLE, 3'd1, 16'hFFFF);
        push_req(REQ_DELETE, 3'd2, 16'd0);
        push_req(REQ_DISABLE, 3'd7, 16'd0);
        push_req(REQ_TOUCH, 3'd7, 16'h5555);
        push_req(REQ_TICK, 3'd7, 16'd0);
        push_req(REQ_TICK, 3'd0, 16'd0);
        push_req(REQ_DELETE, 3'd4, 16'd0);
        push_req(REQ_DISABLE, 3'd5, 16'd0);
        push_req(REQ_TOUCH, 3'd6, 16'hAAAA);
        push_req(REQ_DELETE, 3'd0, 16'd0);
        push_req(REQ_TOUCH, 3'd0, 16'd3);
        push_req(REQ_DELETE, 3'd3, 16'd0);
        push_req(REQ_TICK, 3'd5, 16'hFFFF);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_and_settle();
            case (ph)
                0: next_window = 16'd0;
                1: next_window = 16'hFFFF;
                2: next_window = 16'd5;
                3: next_window = 16'($urandom);
                default: next_window = 16'd1;
            endcase
            if (ph == 1)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 34;
            end
            else if (ph == 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_window(next_window);
            repeat (RANDOM_PER_PHASE) request_queue.push_back(random_request());
        end

        drain_and_settle();
        $display("Covered %0d requests (%0d ticks) under six rate-limit windows.",
                 requests_taken, ticks_taken);
        $display("Checked %0d reports: %0d dumps, %0d suppressed, %0d mismatches.",
                 reports_seen, dumps_seen, suppressed_seen, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
